[hw/rtl/mbbd_pkg.sv]
// Shared types and constants for the modulated beam-break detector.
// No dependencies; used by mbbd_step, the top level and the checker.
`timescale 1ns / 1ps

package mbbd_pkg;

   localparam int unsigned SampleWidth = 13;
   localparam int unsigned CountWidth  = 8;
   localparam int unsigned TotalWidth  = 16;

   localparam logic [SampleWidth-1:0] FULL_SCALE_MV = 13'd5000;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_INTENSITY_THRESHOLD = 2'd0,
      CSR_PULSES_TO_CONNECT   = 2'd1,
      CSR_WEAK_TO_BREAK       = 2'd2
   } csr_index_type;

   localparam logic [SampleWidth-1:0] THRESHOLD_RESET = 13'd300;
   localparam logic [CountWidth-1:0]  PULSES_RESET    = 8'd1;
   localparam logic [CountWidth-1:0]  WEAK_RESET      = 8'd2;

   typedef struct packed {
      logic [SampleWidth-1:0] previous_level;
      logic                   signal_seen;
      logic                   link_up;
      logic [CountWidth-1:0]  pulse_count;
      logic [CountWidth-1:0]  weak_count;
      logic [TotalWidth-1:0]  breaks_total;
   } det_state_type;

   typedef struct packed {
      logic [SampleWidth-1:0] intensity_threshold;
      logic [CountWidth-1:0]  pulses_to_connect;
      logic [CountWidth-1:0]  weak_to_break;
   } det_cfg_type;

endpackage

[hw/rtl/mbbd_step.sv]
// Next-state logic of the detector for one sample: level inversion,
// phase difference, threshold compare and the seen/linked state machine.
// Depends on mbbd_pkg.
`timescale 1ns / 1ps

module mbbd_step import mbbd_pkg::*; (
   input  det_cfg_type            cfg,
   input  det_state_type          state_cur,
   input  logic [SampleWidth-1:0] adc_sample,
   input  logic                   laser_on,
   output det_state_type          state_nxt,
   output logic                   beam_break
);

   logic [SampleWidth-1:0] level;
   logic [SampleWidth-1:0] change;
   logic                   pulse_strong;
   logic [CountWidth-1:0]  pulse_inc;
   logic [CountWidth-1:0]  weak_inc;

   always_comb begin
      // Samples beyond full scale saturate to no light at all.
      level = (adc_sample > FULL_SCALE_MV) ? '0 : FULL_SCALE_MV - adc_sample;
      change = '0;
      if (laser_on) begin
         if (level > state_cur.previous_level) begin
            change = level - state_cur.previous_level;
         end
      end else begin
         if (state_cur.previous_level > level) begin
            change = state_cur.previous_level - level;
         end
      end
      pulse_strong = (change >= cfg.intensity_threshold);
      pulse_inc = state_cur.pulse_count + 8'd1;
      weak_inc = state_cur.weak_count + 8'd1;

      state_nxt = state_cur;
      state_nxt.previous_level = level;
      beam_break = 1'b0;

      if (pulse_strong) begin
         case ({state_cur.signal_seen, state_cur.link_up})
            2'b00: begin
               state_nxt.signal_seen = 1'b1;
            end
            2'b10: begin
               state_nxt.pulse_count = pulse_inc;
               if (pulse_inc >= cfg.pulses_to_connect) begin
                  state_nxt.link_up = 1'b1;
                  state_nxt.pulse_count = '0;
               end
            end
            2'b11: begin
               state_nxt.weak_count = '0;
            end
            default: begin
               // Linked without a seen pulse: drop back to the start.
               state_nxt.signal_seen = 1'b0;
               state_nxt.pulse_count = '0;
               state_nxt.link_up = 1'b0;
            end
         endcase
      end else begin
         case ({state_cur.signal_seen, state_cur.link_up})
            2'b10: begin
               state_nxt.signal_seen = 1'b0;
            end
            2'b11: begin
               state_nxt.weak_count = weak_inc;
               if (weak_inc >= cfg.weak_to_break) begin
                  state_nxt.weak_count = '0;
                  state_nxt.link_up = 1'b0;
                  state_nxt.signal_seen = 1'b0;
                  state_nxt.breaks_total = state_cur.breaks_total + 16'd1;
                  beam_break = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

[hw/rtl/modulated_beam_break_detector.sv]
// Top level of the modulated beam-break detector: input register, state
// registers, configuration registers and result register.
// Depends on mbbd_pkg and mbbd_step.
`timescale 1ns / 1ps

// Usage:
// Each req_ beat carries one ADC sample and the laser phase at that sample.
// Each sample yields exactly one rsp_ beat with the link flag, a break pulse
// and the running break count, in the order the samples arrived.
// A taken sample waits in the input register and then moves into the result
// register, which drives rsp_valid. Throughput is one sample per cycle while
// the receiver does not stall; the detector state is updated as a sample moves
// from the input register into the result register.
// When the receiver stalls, the result register holds its beat and the input
// register can still take one more sample; req_ready drops only when both
// are full. Reset empties both registers, clears the detector state and
// loads the configuration defaults (threshold 300, pulses 1, weak 2).
// Configuration is written through csr_; the user must write it only while no
// samples are in flight, as the block itself does not enforce this. An index
// outside the register list is ignored.

module modulated_beam_break_detector import mbbd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SampleWidth-1:0] req_adc_sample,
   input  logic                   req_laser_on,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_connected,
   output logic                   rsp_beam_break,
   output logic [TotalWidth-1:0]  rsp_break_count,
   input  logic                   csr_write,
   input  logic [1:0]             csr_index,
   input  logic [SampleWidth-1:0] csr_wdata
);

   det_cfg_type            cfg_ff, cfg_in;
   det_state_type          state_ff, state_in, state_step;
   logic                   in_valid_ff;
   logic [SampleWidth-1:0] in_sample_ff;
   logic                   in_laser_ff;
   logic                   out_valid_ff, out_valid_in;
   logic                   out_connected_ff;
   logic                   out_break_ff;
   logic [TotalWidth-1:0]  out_count_ff;
   logic                   step_break;
   logic                   advance;
   logic                   req_take;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   mbbd_step u_step (
      .cfg        (cfg_ff),
      .state_cur  (state_ff),
      .adc_sample (in_sample_ff),
      .laser_on   (in_laser_ff),
      .state_nxt  (state_step),
      .beam_break (step_break)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_INTENSITY_THRESHOLD: cfg_in.intensity_threshold = csr_wdata;
            CSR_PULSES_TO_CONNECT:   cfg_in.pulses_to_connect = csr_wdata[CountWidth-1:0];
            CSR_WEAK_TO_BREAK:       cfg_in.weak_to_break = csr_wdata[CountWidth-1:0];
            default: begin
            end
         endcase
      end
      state_in = advance ? state_step : state_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{THRESHOLD_RESET, PULSES_RESET, WEAK_RESET};
         state_ff     <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         in_valid_ff  <= req_take || (in_valid_ff && !advance);
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_sample_ff <= req_adc_sample;
         in_laser_ff  <= req_laser_on;
      end
      if (advance) begin
         out_connected_ff <= state_step.link_up;
         out_break_ff     <= step_break;
         out_count_ff     <= state_step.breaks_total;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_connected   = out_connected_ff;
   assign rsp_beam_break  = out_break_ff;
   assign rsp_break_count = out_count_ff;

endmodule

[hw/rtl/mbbd_checker.sv]
// Port-level checks for the modulated beam-break detector, bound to the top.
// Depends on mbbd_pkg and modulated_beam_break_detector.
`timescale 1ns / 1ps

module mbbd_checker import mbbd_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_connected,
   input logic                  rsp_beam_break,
   input logic [TotalWidth-1:0] rsp_break_count
);

   // The result register is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // A stalled result beat holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_connected)
         && $stable(rsp_beam_break) && $stable(rsp_break_count))
      else $error("stalled rsp beat changed");

   // A declared break always drops the link.
   a_break_unlinks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beam_break |-> !rsp_connected)
      else $error("beam break reported while connected");

   // Back-to-back result beats: the count moves by one exactly on a break.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) ##1 (rsp_valid && rsp_ready)
         |-> rsp_break_count == $past(rsp_break_count)
            + TotalWidth'(rsp_beam_break))
      else $error("break count step does not match break flag");

endmodule

bind modulated_beam_break_detector mbbd_checker u_mbbd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_connected   (rsp_connected),
   .rsp_beam_break  (rsp_beam_break),
   .rsp_break_count (rsp_break_count)
);

[bench/tb_top.sv]
// Self-checking bench for the modulated beam-break detector: random and directed
// samples, random stalls on both channels, and an in-bench prediction of every beat.
// Depends on mbbd_pkg and the modulated_beam_break_detector RTL.
`timescale 1ns / 1ps

module tb_top;
   import mbbd_pkg::*;

   localparam logic [1:0] CSR_UNMAPPED   = 2'd3;
   localparam int         WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [SampleWidth-1:0] adc_sample;
      logic                   laser_on;
   } sample_beat_type;

   typedef struct packed {
      logic                  connected;
      logic                  beam_break;
      logic [TotalWidth-1:0] break_count;
   } outcome_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [SampleWidth-1:0] req_adc_sample = '0;
   logic                   req_laser_on = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_connected;
   logic                   rsp_beam_break;
   logic [TotalWidth-1:0]  rsp_break_count;
   logic                   csr_write = 1'b0;
   logic [1:0]             csr_index = '0;
   logic [SampleWidth-1:0] csr_wdata = '0;

   // Bench copy of the configuration and the detector state.
   logic [SampleWidth-1:0] cfg_threshold = THRESHOLD_RESET;
   logic [CountWidth-1:0]  cfg_pulses = PULSES_RESET;
   logic [CountWidth-1:0]  cfg_weak = WEAK_RESET;
   logic [SampleWidth-1:0] last_level = '0;
   logic                   pulse_seen = 1'b0;
   logic                   link_on = 1'b0;
   logic [CountWidth-1:0]  strong_run = '0;
   logic [CountWidth-1:0]  weak_run = '0;
   logic [TotalWidth-1:0]  break_tally = '0;

   sample_beat_type sample_queue[$];
   outcome_type     expected_outcomes[$];
   sample_beat_type next_beat;
   outcome_type     seen_outcome;
   outcome_type     want_outcome;

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_sender = 1'b0;
   int  mismatch_count = 0;
   int  samples_sent = 0;
   int  results_checked = 0;
   int  links_made = 0;
   int  settings_used = 1;
   int  stall_cycles = 0;

   modulated_beam_break_detector DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_adc_sample (req_adc_sample),
      .req_laser_on   (req_laser_on),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_connected  (rsp_connected),
      .rsp_beam_break (rsp_beam_break),
      .rsp_break_count(rsp_break_count),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #5 clock = ~clock;

   // Advances the bench copy of the detector by one sample and returns its beat.
   function automatic outcome_type predict_outcome(logic [SampleWidth-1:0] sample,
                                                   logic laser);
      logic [SampleWidth-1:0] level;
      logic [SampleWidth-1:0] delta;
      logic                   broke;
      outcome_type            res;
      level = (sample > FULL_SCALE_MV) ? '0 : FULL_SCALE_MV - sample;
      delta = '0;
      broke = 1'b0;
      if (laser && level > last_level) delta = level - last_level;
      else if (!laser && last_level > level) delta = last_level - level;
      if (delta >= cfg_threshold) begin
         if (!pulse_seen && !link_on) begin
            pulse_seen = 1'b1;
         end else if (pulse_seen && !link_on) begin
            strong_run = strong_run + 1'b1;
            if (strong_run >= cfg_pulses) begin
               link_on = 1'b1;
               strong_run = '0;
               links_made++;
            end
         end else if (pulse_seen && link_on) begin
            weak_run = '0;
         end else begin
            pulse_seen = 1'b0;
            strong_run = '0;
            link_on = 1'b0;
         end
      end else if (pulse_seen && !link_on) begin
         pulse_seen = 1'b0;
      end else if (pulse_seen && link_on) begin
         weak_run = weak_run + 1'b1;
         if (weak_run >= cfg_weak) begin
            weak_run = '0;
            link_on = 1'b0;
            pulse_seen = 1'b0;
            break_tally = break_tally + 1'b1;
            broke = 1'b1;
         end
      end
      last_level = level;
      res.connected = link_on;
      res.beam_break = broke;
      res.break_count = break_tally;
      return res;
   endfunction

   task automatic flag_mismatch(string what, outcome_type want, outcome_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: expected connected=%0b break=%0b count=%0d, got %0b %0b %0d",
                  $realtime, what, want.connected, want.beam_break, want.break_count,
                  got.connected, got.beam_break, got.break_count);
   endtask

   // Sample driver: holds each beat until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_outcomes.push_back(predict_outcome(req_adc_sample, req_laser_on));
            samples_sent++;
         end
         if (!req_valid || req_ready) begin
            if (!hold_sender && sample_queue.size() != 0
                && $urandom_range(0, 99) >= send_idle_pct) begin
               next_beat = sample_queue.pop_front();
               req_valid <= 1'b1;
               req_adc_sample <= next_beat.adc_sample;
               req_laser_on <= next_beat.laser_on;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen_outcome = '{rsp_connected, rsp_beam_break, rsp_break_count};
            if (expected_outcomes.size() == 0) begin
               flag_mismatch("beat with nothing expected", '0, seen_outcome);
            end else begin
               want_outcome = expected_outcomes.pop_front();
               if (seen_outcome.connected !== want_outcome.connected
                   || seen_outcome.beam_break !== want_outcome.beam_break
                   || seen_outcome.break_count !== want_outcome.break_count)
                  flag_mismatch("result mismatch", want_outcome, seen_outcome);
            end
            results_checked++;
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write) begin
         stall_cycles <= 0;
      end else if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic push_sample(logic [SampleWidth-1:0] adc, logic laser);
      sample_beat_type beat;
      beat.adc_sample = adc;
      beat.laser_on = laser;
      sample_queue.push_back(beat);
   endtask

   // A zero level is sometimes sent as a saturated sample at or above full scale.
   function automatic logic [SampleWidth-1:0] adc_for_level(int lvl);
      logic [SampleWidth-1:0] adc;
      if (lvl == 0 && $urandom_range(0, 1) == 1)
         adc = SampleWidth'(5000 + $urandom_range(0, 3191));
      else adc = SampleWidth'(5000 - lvl);
      return adc;
   endfunction

   // Samples with the laser toggling each beat. With the beam present the lit
   // level steps up by the threshold plus up to 250, at most 5000; with it blocked
   // the level only jitters by less than a nonzero threshold and by at most 400.
   // A marginal run with a threshold from 1 to 5000 lands on the threshold or one below it.
   task automatic queue_beam(int count, bit present, bit marginal);
      int thr;
      int amp;
      int span;
      int floor_lvl;
      int lvl;
      bit lit;
      thr = int'(cfg_threshold);
      amp = thr + $urandom_range(0, 250);
      if (amp > 5000) amp = 5000;
      span = (thr > 400) ? 400 : ((thr > 0) ? thr - 1 : 0);
      floor_lvl = $urandom_range(0, 5000 - (present ? amp : span));
      lit = 1'($urandom_range(0, 1));
      for (int k = 0; k < count; k++) begin
         if (!present) lvl = floor_lvl + $urandom_range(0, span);
         else if (!lit) lvl = floor_lvl;
         else if (marginal && thr > 0 && thr <= 5000) lvl = floor_lvl + thr - $urandom_range(0, 1);
         else lvl = floor_lvl + amp;
         push_sample(adc_for_level(lvl), lit);
         lit = !lit;
      end
   endtask

   // Mostly beam-present and beam-blocked runs, with some raw noise between them.
   task automatic queue_mix(int total);
      int n;
      int pick;
      while (total > 0) begin
         pick = $urandom_range(0, 19);
         if (pick < 10) n = $urandom_range(2, 2 * cfg_pulses + 12);
         else if (pick < 17) n = $urandom_range(1, cfg_weak + 5);
         else n = $urandom_range(1, 6);
         if (n > total) n = total;
         if (pick < 10) queue_beam(n, 1'b1, $urandom_range(0, 3) == 0);
         else if (pick < 17) queue_beam(n, 1'b0, 1'b0);
         else repeat (n) push_sample(SampleWidth'($urandom_range(0, 8191)),
                                     1'($urandom_range(0, 1)));
         total -= n;
      end
   endtask

   task automatic write_csr(logic [1:0] idx, logic [SampleWidth-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_INTENSITY_THRESHOLD: cfg_threshold = value;
         CSR_PULSES_TO_CONNECT:   cfg_pulses = value[CountWidth-1:0];
         CSR_WEAK_TO_BREAK:       cfg_weak = value[CountWidth-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(logic [SampleWidth-1:0] thr, logic [SampleWidth-1:0] pulses,
                                 logic [SampleWidth-1:0] weak_limit);
      write_csr(CSR_INTENSITY_THRESHOLD, thr);
      write_csr(CSR_PULSES_TO_CONNECT, pulses);
      write_csr(CSR_WEAK_TO_BREAK, weak_limit);
      @(posedge clock);
      csr_write <= 1'b0;
      settings_used++;
      @(negedge clock);
   endtask

   // Waits until every sample has been taken and answered, then lets the
   // pipeline settle before anything else changes.
   task automatic wait_until_idle();
      while (sample_queue.size() != 0 || req_valid || expected_outcomes.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct = 6;
      recv_idle_pct = 54;

      // Default settings: link and break, then exact-threshold steps.
      push_sample(13'd5000, 1'b1);
      push_sample(13'd0, 1'b1);
      push_sample(13'd8191, 1'b0);
      push_sample(13'd5001, 1'b1);
      push_sample(13'd0, 1'b1);
      push_sample(13'd0, 1'b1);
      push_sample(13'd0, 1'b0);
      push_sample(13'd5000, 1'b0);
      push_sample(13'd4700, 1'b1);
      push_sample(13'd5000, 1'b0);
      push_sample(13'd4701, 1'b1);
      push_sample(13'd4999, 1'b0);
      push_sample(13'd0, 1'b0);
      push_sample(13'd4096, 1'b1);
      push_sample(13'd1, 1'b1);
      push_sample(13'd2, 1'b0);
      push_sample(13'd8191, 1'b1);
      queue_mix(250);

      // Hold the sender mid-phase until the block has answered everything.
      while (sample_queue.size() > 125) @(negedge clock);
      hold_sender = 1'b1;
      while (req_valid || expected_outcomes.size() != 0) @(negedge clock);
      hold_sender = 1'b0;
      wait_until_idle();

      // Zero threshold and counts: every sample is strong, even with no change.
      apply_settings(13'd0, 13'd0, 13'd0);
      queue_mix(60);
      wait_until_idle();

      // Unreachable threshold; the upper data bits of the count registers are dropped.
      write_csr(CSR_UNMAPPED, 13'h1FFF);
      apply_settings(13'h1FFF, 13'h1FFF, 13'd255);
      queue_mix(60);
      wait_until_idle();

      send_idle_pct = 54;
      recv_idle_pct = 6;
      apply_settings(13'd5000, 13'd0, 13'd0);
      queue_mix(80);
      wait_until_idle();

      // Largest counts: long blocked and present runs.
      apply_settings(13'd1, 13'd255, 13'd255);
      queue_beam(262, 1'b0, 1'b0);
      queue_beam(270, 1'b1, 1'b0);
      queue_beam(262, 1'b0, 1'b0);
      wait_until_idle();

      for (int p = 0; p < 4; p++) begin
         if (p == 1) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         apply_settings(SampleWidth'($urandom_range(1, 1500)),
                        SampleWidth'($urandom_range(0, 6)),
                        SampleWidth'($urandom_range(0, 6)));
         queue_mix(100);
         wait_until_idle();
      end

      repeat (8) @(negedge clock);
      mismatch_count += expected_outcomes.size();
      $display("%0d samples checked under %0d register settings;", results_checked,
               settings_used);
      $display("%0d links made and %0d beam breaks declared.", links_made, break_tally);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/mbbd_pkg.sv
hw/rtl/mbbd_step.sv
hw/rtl/modulated_beam_break_detector.sv
hw/rtl/mbbd_checker.sv
bench/tb_top.sv
